[design/obb_sat_pkg.sv]
// Shared constants for the oriented box separating-axis test.
`timescale 1ns / 1ps
`default_nettype none
package obb_sat_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int ROT_BITS_DEF = 16;
	localparam int NUM_AXES = 15;
	localparam int FIELD_BITS = 48;
endpackage
`default_nettype wire

[design/obb_sat_prep.sv]
// Front stages: unpack both boxes, form extents, relative rotation and translation.
`timescale 1ns / 1ps
`default_nettype none
module obb_sat_prep #(
	parameter int COORD_BITS = obb_sat_pkg::COORD_BITS_DEF,
	parameter int ROT_BITS = obb_sat_pkg::ROT_BITS_DEF,
	localparam int EW = COORD_BITS + 1,
	localparam int RW = 2 * ROT_BITS + 3,
	localparam int TW = COORD_BITS + ROT_BITS + 3,
	localparam int FB = obb_sat_pkg::FIELD_BITS
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [FB-1:0] box1_min,
	input  wire logic [FB-1:0] box1_max,
	input  wire logic [FB-1:0] box1_row0,
	input  wire logic [FB-1:0] box1_row1,
	input  wire logic [FB-1:0] box1_row2,
	input  wire logic [FB-1:0] box1_pos,
	input  wire logic [FB-1:0] box2_min,
	input  wire logic [FB-1:0] box2_max,
	input  wire logic [FB-1:0] box2_row0,
	input  wire logic [FB-1:0] box2_row1,
	input  wire logic [FB-1:0] box2_row2,
	input  wire logic [FB-1:0] box2_pos,
	output logic signed [EW-1:0] ea_s2 [3],
	output logic signed [EW-1:0] eb_s2 [3],
	output logic signed [TW-1:0] t_s2 [3],
	output logic signed [RW-1:0] r_s2 [3][3]
);
	logic signed [EW-1:0] ea_s1 [3];
	logic signed [EW-1:0] eb_s1 [3];
	logic signed [EW-1:0] v_s1 [3];
	logic signed [ROT_BITS-1:0] a_s1 [3][3];
	logic signed [ROT_BITS-1:0] b_s1 [3][3];
	logic [FB-1:0] arow [3];
	logic [FB-1:0] brow [3];

	assign arow[0] = box1_row0;
	assign arow[1] = box1_row1;
	assign arow[2] = box1_row2;
	assign brow[0] = box2_row0;
	assign brow[1] = box2_row1;
	assign brow[2] = box2_row2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				ea_s1[j] <= EW'($signed(box1_max[j*COORD_BITS +: COORD_BITS]))
					- EW'($signed(box1_min[j*COORD_BITS +: COORD_BITS]));
				eb_s1[j] <= EW'($signed(box2_max[j*COORD_BITS +: COORD_BITS]))
					- EW'($signed(box2_min[j*COORD_BITS +: COORD_BITS]));
				v_s1[j] <= EW'($signed(box2_pos[j*COORD_BITS +: COORD_BITS]))
					- EW'($signed(box1_pos[j*COORD_BITS +: COORD_BITS]));
				for (int i = 0; i < 3; i++) begin
					a_s1[i][j] <= $signed(arow[i][j*ROT_BITS +: ROT_BITS]);
					b_s1[i][j] <= $signed(brow[i][j*ROT_BITS +: ROT_BITS]);
				end
			end
			for (int i = 0; i < 3; i++) begin
				ea_s2[i] <= ea_s1[i];
				eb_s2[i] <= eb_s1[i];
				t_s2[i] <= TW'(v_s1[0]) * TW'(a_s1[i][0]) + TW'(v_s1[1]) * TW'(a_s1[i][1])
					+ TW'(v_s1[2]) * TW'(a_s1[i][2]);
				for (int k = 0; k < 3; k++) begin
					r_s2[i][k] <= RW'(a_s1[i][0]) * RW'(b_s1[k][0])
						+ RW'(a_s1[i][1]) * RW'(b_s1[k][1])
						+ RW'(a_s1[i][2]) * RW'(b_s1[k][2]);
				end
			end
		end
	end
endmodule
`default_nettype wire

[design/obb_sat_lane.sv]
// One axis lane: projected distance against projected radius sum, over two stages.
`timescale 1ns / 1ps
`default_nettype none
module obb_sat_lane #(
	parameter int COORD_BITS = obb_sat_pkg::COORD_BITS_DEF,
	parameter int ROT_BITS = obb_sat_pkg::ROT_BITS_DEF,
	parameter int TSH = 1,
	parameter int RSH = 0,
	parameter int XSH = 0,
	localparam int EW = COORD_BITS + 1,
	localparam int RW = 2 * ROT_BITS + 3,
	localparam int TW = COORD_BITS + ROT_BITS + 3,
	localparam int WW = COORD_BITS + 3 * ROT_BITS + 10
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic signed [TW-1:0] tv [3],
	input  wire logic signed [RW-1:0] rv [3],
	input  wire logic signed [EW-1:0] ev [4],
	input  wire logic signed [RW-1:0] av [4],
	input  wire logic signed [EW-1:0] ex,
	output logic sep_s4
);
	logic signed [WW-1:0] pt_s3 [3];
	logic signed [WW-1:0] pr_s3 [4];
	logic signed [EW-1:0] ex_s3;
	logic signed [WW-1:0] st;
	logic signed [WW-1:0] tm;
	logic signed [WW-1:0] rs;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 3; n++)
				pt_s3[n] <= WW'(tv[n]) * WW'(rv[n]);
			for (int n = 0; n < 4; n++)
				pr_s3[n] <= WW'(ev[n]) * WW'(av[n]);
			ex_s3 <= ex;
		end
	end

	always_comb begin
		st = pt_s3[0] + pt_s3[1] + pt_s3[2];
		tm = (st < 0) ? -st : st;
		tm = tm <<< TSH;
		rs = ((pr_s3[0] + pr_s3[1] + pr_s3[2] + pr_s3[3]) <<< RSH) + (WW'(ex_s3) <<< XSH);
	end

	always_ff @(posedge clk) begin
		if (en)
			sep_s4 <= tm > rs;
	end
endmodule
`default_nettype wire

[design/obb_sat_merge.sv]
// Merge stage: combines the lane verdicts into the registered overlap result.
`timescale 1ns / 1ps
`default_nettype none
module obb_sat_merge (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s4,
	input  wire logic [obb_sat_pkg::NUM_AXES-1:0] sep_s4,
	output logic out_valid_q,
	output logic overlap_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			overlap_q <= ~|sep_s4;
	end
endmodule
`default_nettype wire

[design/obb_sat_top_placeholder_never.sv]
// Axis lane input selection helper: routes shared terms to one lane.
`timescale 1ns / 1ps
`default_nettype none
module obb_sat_route #(
	parameter int COORD_BITS = obb_sat_pkg::COORD_BITS_DEF,
	parameter int ROT_BITS = obb_sat_pkg::ROT_BITS_DEF,
	parameter int AXIS = 0,
	localparam int EW = COORD_BITS + 1,
	localparam int RW = 2 * ROT_BITS + 3,
	localparam int TW = COORD_BITS + ROT_BITS + 3,
	localparam int FR = ROT_BITS - 2
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic signed [EW-1:0] ea [3],
	input  wire logic signed [EW-1:0] eb [3],
	input  wire logic signed [TW-1:0] t [3],
	input  wire logic signed [RW-1:0] r [3][3],
	output logic sep_s4
);
	logic signed [RW-1:0] ar [3][3];
	logic signed [TW-1:0] tv [3];
	logic signed [RW-1:0] rv [3];
	logic signed [EW-1:0] ev [4];
	logic signed [RW-1:0] av [4];
	logic signed [EW-1:0] ex;

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				ar[i][k] = (r[i][k] < 0) ? -r[i][k] : r[i][k];
	end

	if (AXIS < 3) begin : g_face_a
		always_comb begin
			tv[0] = t[AXIS];
			rv[0] = RW'(1);
			tv[1] = '0;
			rv[1] = '0;
			tv[2] = '0;
			rv[2] = '0;
			for (int j = 0; j < 3; j++) begin
				ev[j] = eb[j];
				av[j] = ar[AXIS][j];
			end
			ev[3] = '0;
			av[3] = '0;
			ex = ea[AXIS];
		end
		obb_sat_lane #(.COORD_BITS(COORD_BITS), .ROT_BITS(ROT_BITS),
			.TSH(FR + 1), .RSH(0), .XSH(2 * FR)) u_lane (
			.clk(clk), .en(en), .tv(tv), .rv(rv), .ev(ev), .av(av), .ex(ex),
			.sep_s4(sep_s4));
	end else if (AXIS < 6) begin : g_face_b
		localparam int K = AXIS - 3;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				tv[i] = t[i];
				rv[i] = r[i][K];
				ev[i] = ea[i];
				av[i] = ar[i][K];
			end
			ev[3] = '0;
			av[3] = '0;
			ex = eb[K];
		end
		obb_sat_lane #(.COORD_BITS(COORD_BITS), .ROT_BITS(ROT_BITS),
			.TSH(1), .RSH(FR), .XSH(3 * FR)) u_lane (
			.clk(clk), .en(en), .tv(tv), .rv(rv), .ev(ev), .av(av), .ex(ex),
			.sep_s4(sep_s4));
	end else begin : g_edge
		localparam int I = (AXIS - 6) / 3;
		localparam int K = (AXIS - 6) % 3;
		localparam int I1 = (I + 1) % 3;
		localparam int I2 = (I + 2) % 3;
		localparam int K1 = (K + 1) % 3;
		localparam int K2 = (K + 2) % 3;
		always_comb begin
			tv[0] = t[I2];
			rv[0] = r[I1][K];
			tv[1] = t[I1];
			rv[1] = -r[I2][K];
			tv[2] = '0;
			rv[2] = '0;
			ev[0] = ea[I1];
			av[0] = ar[I2][K];
			ev[1] = ea[I2];
			av[1] = ar[I1][K];
			ev[2] = eb[K1];
			av[2] = ar[I][K2];
			ev[3] = eb[K2];
			av[3] = ar[I][K1];
			ex = '0;
		end
		obb_sat_lane #(.COORD_BITS(COORD_BITS), .ROT_BITS(ROT_BITS),
			.TSH(1), .RSH(FR), .XSH(0)) u_lane (
			.clk(clk), .en(en), .tv(tv), .rv(rv), .ev(ev), .av(av), .ex(ex),
			.sep_s4(sep_s4));
	end
endmodule
`default_nettype wire

[design/obb_separating_axis_test_core.sv]
// Top level of the oriented box overlap test: a prep stage, 15 axis lanes and a merge stage.
// Usage:
//   Input channel in_valid/in_ready carries one beat per box pair: twelve
//   packed 48-bit vectors (corners, rotation rows and position of each box).
//   Output channel out_valid/out_ready carries one beat per pair: overlap.
//   Pipeline: an accepted input beat passes through five registered stages
//   (unpack, rotation/translation, lane products, lane compare, merge
//   register). The fifteen axes run in parallel lanes, so one pair is
//   accepted every cycle while the receiver does not stall.
//   When the receiver stalls, the whole pipeline holds and in_ready drops
//   while the output beat waits; it rises as soon as that beat is taken.
//   Reset clears all stage valid bits; no beat is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module obb_separating_axis_test_core #(
	parameter int COORD_BITS = obb_sat_pkg::COORD_BITS_DEF,
	parameter int ROT_BITS = obb_sat_pkg::ROT_BITS_DEF,
	localparam int EW = COORD_BITS + 1,
	localparam int RW = 2 * ROT_BITS + 3,
	localparam int TW = COORD_BITS + ROT_BITS + 3,
	localparam int FB = obb_sat_pkg::FIELD_BITS,
	localparam int NA = obb_sat_pkg::NUM_AXES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [FB-1:0] box1_min,
	input  wire logic [FB-1:0] box1_max,
	input  wire logic [FB-1:0] box1_row0,
	input  wire logic [FB-1:0] box1_row1,
	input  wire logic [FB-1:0] box1_row2,
	input  wire logic [FB-1:0] box1_pos,
	input  wire logic [FB-1:0] box2_min,
	input  wire logic [FB-1:0] box2_max,
	input  wire logic [FB-1:0] box2_row0,
	input  wire logic [FB-1:0] box2_row1,
	input  wire logic [FB-1:0] box2_row2,
	input  wire logic [FB-1:0] box2_pos,
	output logic out_valid,
	input  wire logic out_ready,
	output logic overlap
);
	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [EW-1:0] ea_s2 [3];
	logic signed [EW-1:0] eb_s2 [3];
	logic signed [TW-1:0] t_s2 [3];
	logic signed [RW-1:0] r_s2 [3][3];
	logic [NA-1:0] sep_s4;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	obb_sat_prep #(.COORD_BITS(COORD_BITS), .ROT_BITS(ROT_BITS)) u_prep (
		.clk(clk), .en(en),
		.box1_min(box1_min), .box1_max(box1_max), .box1_row0(box1_row0),
		.box1_row1(box1_row1), .box1_row2(box1_row2), .box1_pos(box1_pos),
		.box2_min(box2_min), .box2_max(box2_max), .box2_row0(box2_row0),
		.box2_row1(box2_row1), .box2_row2(box2_row2), .box2_pos(box2_pos),
		.ea_s2(ea_s2), .eb_s2(eb_s2), .t_s2(t_s2), .r_s2(r_s2));

	for (genvar l = 0; l < NA; l++) begin : g_axis
		obb_sat_route #(.COORD_BITS(COORD_BITS), .ROT_BITS(ROT_BITS), .AXIS(l)) u_route (
			.clk(clk), .en(en), .ea(ea_s2), .eb(eb_s2), .t(t_s2), .r(r_s2),
			.sep_s4(sep_s4[l]));
	end

	obb_sat_merge u_merge (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_s4(v_s4), .sep_s4(sep_s4),
		.out_valid_q(out_valid), .overlap_q(overlap));

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4}))
		else $error("pipeline valid bits moved during a stall");

	a_out_from_stage4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s4))
		else $error("output beat appeared without a stage four item");

	a_ready_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register is empty");
endmodule
`default_nettype wire

[sim/obb_separating_axis_test_core_test.sv]
// Self-checking testbench of the oriented box overlap core, with directed and random box pairs.
`timescale 1ns / 1ps
module obb_separating_axis_test_core_test;
	localparam int CW = obb_sat_pkg::COORD_BITS_DEF;
	localparam int RWB = obb_sat_pkg::ROT_BITS_DEF;
	localparam int FB = obb_sat_pkg::FIELD_BITS;
	localparam int FR = RWB - 2;
	localparam int ONE_R = 1 << FR;
	localparam int RANDOM_PAIRS = 1200;
	localparam int HOLD_CYCLES = 300;

	typedef logic [FB-1:0] pair_fields_t [12];
	typedef logic signed [127:0] wide_t;
	typedef struct {
		pair_fields_t f;
		int known;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic overlap;
	logic [FB-1:0] fld [12];

	bit overlap_expect [$];
	int mismatches = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	bit sending_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (fld[n])
			fld[n] = '0;
	end

	obb_separating_axis_test_core uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.box1_min(fld[0]), .box1_max(fld[1]), .box1_row0(fld[2]), .box1_row1(fld[3]),
		.box1_row2(fld[4]), .box1_pos(fld[5]), .box2_min(fld[6]), .box2_max(fld[7]),
		.box2_row0(fld[8]), .box2_row1(fld[9]), .box2_row2(fld[10]), .box2_pos(fld[11]),
		.out_valid(out_valid), .out_ready(out_ready), .overlap(overlap)
	);

	function automatic logic [FB-1:0] pack3(int x, int y, int z);
		logic [CW-1:0] a, b, c;
		a = x[CW-1:0];
		b = y[CW-1:0];
		c = z[CW-1:0];
		return {c, b, a};
	endfunction

	function automatic longint comp(logic [FB-1:0] w, int j);
		logic signed [CW-1:0] c;
		c = w[CW*j +: CW];
		return longint'(c);
	endfunction

	function automatic wide_t wmul(longint x, longint y);
		return wide_t'(x) * wide_t'(y);
	endfunction

	function automatic wide_t wabs(wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	// Exact overlap decision over all fifteen candidate axes.
	function automatic bit boxes_overlap(pair_fields_t f);
		longint a [3][3], b [3][3], rr [3][3], ar [3][3], tr [3], d [3], ea [3], eb [3];
		wide_t t, r, s;
		int i1, i2, k1, k2;
		bit sep;
		sep = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				a[i][j] = comp(f[2+i], j);
				b[i][j] = comp(f[8+i], j);
			end
		for (int j = 0; j < 3; j++) begin
			ea[j] = comp(f[1], j) - comp(f[0], j);
			eb[j] = comp(f[7], j) - comp(f[6], j);
			d[j] = comp(f[11], j) - comp(f[5], j);
		end
		for (int i = 0; i < 3; i++) begin
			tr[i] = d[0] * a[i][0] + d[1] * a[i][1] + d[2] * a[i][2];
			for (int k = 0; k < 3; k++) begin
				rr[i][k] = a[i][0] * b[k][0] + a[i][1] * b[k][1] + a[i][2] * b[k][2];
				ar[i][k] = (rr[i][k] < 0) ? -rr[i][k] : rr[i][k];
			end
		end
		for (int i = 0; i < 3; i++) begin
			t = wabs(wide_t'(tr[i])) <<< (FR + 1);
			r = wide_t'(ea[i]) <<< (2 * FR);
			for (int j = 0; j < 3; j++)
				r = r + wmul(eb[j], ar[i][j]);
			if (t > r)
				sep = 1'b1;
		end
		for (int k = 0; k < 3; k++) begin
			s = 0;
			r = 0;
			for (int i = 0; i < 3; i++) begin
				s = s + wmul(tr[i], rr[i][k]);
				r = r + wmul(ea[i], ar[i][k]);
			end
			t = wabs(s) <<< 1;
			r = (r <<< FR) + (wide_t'(eb[k]) <<< (3 * FR));
			if (t > r)
				sep = 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			i1 = (i + 1) % 3;
			i2 = (i + 2) % 3;
			for (int k = 0; k < 3; k++) begin
				k1 = (k + 1) % 3;
				k2 = (k + 2) % 3;
				r = wmul(ea[i1], ar[i2][k]) + wmul(ea[i2], ar[i1][k])
					+ wmul(eb[k1], ar[i][k2]) + wmul(eb[k2], ar[i][k1]);
				r = r <<< FR;
				t = wabs(wmul(tr[i2], rr[i1][k]) - wmul(tr[i1], rr[i2][k])) <<< 1;
				if (t > r)
					sep = 1'b1;
			end
		end
		return !sep;
	endfunction

	function automatic int srand(int lim);
		return int'($urandom_range(2 * lim)) - lim;
	endfunction

	// Rotation about one axis by an angle from a short table, random sign.
	function automatic void make_rotation(ref pair_fields_t f, input int base);
		int cs [4] = '{16384, 15137, 11585, 6270};
		int sn [4] = '{0, 6270, 11585, 15137};
		int m [3][3];
		int k, p, q, idx, sg;
		k = $urandom_range(2);
		p = (k + 1) % 3;
		q = (k + 2) % 3;
		idx = $urandom_range(3);
		sg = $urandom_range(1) ? 1 : -1;
		foreach (m[i, j])
			m[i][j] = 0;
		m[k][k] = ONE_R;
		m[p][p] = cs[idx];
		m[q][q] = cs[idx];
		m[p][q] = -sg * sn[idx];
		m[q][p] = sg * sn[idx];
		for (int i = 0; i < 3; i++)
			f[base + i] = pack3(m[i][0], m[i][1], m[i][2]);
	endfunction

	function automatic void make_pair(ref pair_fields_t f);
		int mode;
		mode = $urandom_range(99);
		if (mode < 15) begin
			foreach (f[n])
				f[n] = FB'({$urandom(), $urandom()});
		end else begin
			f[0] = pack3(-$urandom_range(1500, 1), -$urandom_range(1500, 1), -$urandom_range(1500, 1));
			f[1] = pack3($urandom_range(1500, 1), $urandom_range(1500, 1), $urandom_range(1500, 1));
			f[6] = pack3(-$urandom_range(1500, 1), -$urandom_range(1500, 1), -$urandom_range(1500, 1));
			f[7] = pack3($urandom_range(1500, 1), $urandom_range(1500, 1), $urandom_range(1500, 1));
			f[5] = pack3(srand(3000), srand(3000), srand(3000));
			f[11] = pack3(srand(3000), srand(3000), srand(3000));
			make_rotation(f, 2);
			make_rotation(f, 8);
			if (mode < 25)
				f[$urandom_range(11)] = FB'({$urandom(), $urandom()});
		end
	endfunction

	function automatic void identity_pair(ref pair_fields_t f, input int half, input int dx);
		f[0] = pack3(-half, -half, -half);
		f[1] = pack3(half, half, half);
		f[6] = f[0];
		f[7] = f[1];
		f[2] = pack3(ONE_R, 0, 0);
		f[3] = pack3(0, ONE_R, 0);
		f[4] = pack3(0, 0, ONE_R);
		f[8] = f[2];
		f[9] = f[3];
		f[10] = f[4];
		f[5] = pack3(0, 0, 0);
		f[11] = pack3(dx, 0, 0);
	endfunction

	task automatic send_pair(pair_fields_t f, int known);
		int gap;
		gap = no_idle ? 0 : $urandom_range(17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		foreach (fld[n])
			fld[n] <= f[n];
		do
			@(posedge clk);
		while (!in_ready);
		overlap_expect.push_back(known >= 0 ? bit'(known) : boxes_overlap(f));
	endtask

	initial begin
		directed_row_t rows [$];
		directed_row_t row;
		pair_fields_t f;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (row.f[n])
			row.f[n] = '0;
		row.known = 1;
		rows.push_back(row);
		foreach (row.f[n])
			row.f[n] = '1;
		rows.push_back(row);
		identity_pair(row.f, 256, 0);
		rows.push_back(row);
		identity_pair(row.f, 256, 512);
		rows.push_back(row);
		identity_pair(row.f, 256, 513);
		row.known = 0;
		rows.push_back(row);
		identity_pair(row.f, 256, 5000);
		rows.push_back(row);
		identity_pair(row.f, 256, 0);
		row.f[0] = pack3(256, 256, 256);
		row.f[1] = pack3(-256, -256, -256);
		row.known = 1;
		rows.push_back(row);
		identity_pair(row.f, 0, 0);
		row.f[0] = pack3(-32768, -32768, -32768);
		row.f[1] = pack3(32767, 32767, 32767);
		row.f[6] = row.f[0];
		row.f[7] = row.f[1];
		row.f[5] = pack3(-32768, -32768, -32768);
		row.f[11] = pack3(32767, 32767, 32767);
		row.known = -1;
		rows.push_back(row);
		for (int n = 0; n < 6; n++) begin
			identity_pair(row.f, 300, 400);
			row.f[2 + (n % 3)] = (n < 3) ? pack3(32767, 32767, 32767) : pack3(-32768, -32768, -32768);
			row.f[8 + (n % 3)] = pack3(-32768, 32767, -32768);
			rows.push_back(row);
		end
		for (int n = 0; n < 6; n++) begin
			make_pair(row.f);
			make_rotation(row.f, 2);
			make_rotation(row.f, 8);
			rows.push_back(row);
		end
		foreach (rows[n])
			send_pair(rows[n].f, rows[n].known);

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			no_idle = (n >= 300 && n < 450);
			if (n == 700)
				hold_req = 1'b1;
			make_pair(f);
			send_pair(f, -1);
		end
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	initial begin
		int stall;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = no_idle ? 0 : $urandom_range(17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(out_valid && arst_n));
			if (overlap_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: overlap=%b", overlap);
			end else begin
				bit want;
				want = overlap_expect.pop_front();
				if (overlap !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("overlap mismatch: expected %b, got %b", want, overlap);
				end
			end
		end
	end

	initial begin
		wait (sending_done);
		wait (overlap_expect.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("obb_separating_axis_test_core_test passed");
		else
			$display("obb_separating_axis_test_core_test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("obb_separating_axis_test_core_test failed");
		$finish;
	end
endmodule
